### rtl/zrt_pkg.sv
// ----------------------------------------------------------------------------
// zrt_pkg
// Shared types, constants and helpers for the zone relay timer table.
// ----------------------------------------------------------------------------
package zrt_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int TIME_BITS_DEF  = 32;
    localparam int ZONE_COUNT     = 4;

    localparam logic [31:0] HOLD_TIME_RESET = 32'd1000;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  zone_index;
        logic [31:0] run_duration;
        logic [31:0] current_time;
        logic        override_level;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [3:0] relay_mask;
        logic [3:0] started_mask;
        logic [3:0] stopped_mask;
        logic       override_fired;
    } t_rsp;

    // relay bit of a zone; zones above 4 fall off the 4-bit mask
    function automatic logic [3:0] zone_bit(input logic [2:0] zone);
        logic [7:0] w;
        w = 8'd1 << (zone - 3'd1);
        return w[3:0];
    endfunction

endpackage

### rtl/zrt_addcmp.sv
// ----------------------------------------------------------------------------
// zrt_addcmp
// Shared time unit: wrapped sum a + b, and sum < c.
// ----------------------------------------------------------------------------
module zrt_addcmp #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] i_a,
    input  logic [TIME_BITS-1:0] i_b,
    input  logic [TIME_BITS-1:0] i_c,
    output logic [TIME_BITS-1:0] o_sum,
    output logic                 o_lt
);

    assign o_sum = i_a + i_b;
    assign o_lt  = o_sum < i_c;

endmodule

### rtl/zone_relay_timer_table.sv
// ----------------------------------------------------------------------------
// zone_relay_timer_table
// Multi-zone relay timer: on/off commands claim and end slots, ticks start,
// time out and override-stop zones. One shared add/compare unit is walked
// over the slots by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   i_in_valid  o_in_stall  i_in_data   in  (t_req)
//  result    o_out_valid i_out_stall o_out_data  out (t_rsp)
//  config    i_cfg_we    i_cfg_wdata             in  (override hold time)
//
//  A tick runs one override step, then one slot per cycle through the shared
//  add/compare unit; on and off commands search the slots in turn and then
//  apply the command. Opcode three goes straight to the result step.
//  o_in_stall is high while a request is in work; a finished result waits in
//  the output register, and the sequencer holds in its last step only if a
//  second result is ready before the first is taken.
//  Reset is synchronous, active low; the table comes out empty.
// ----------------------------------------------------------------------------
module zone_relay_timer_table
    import zrt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVR,
        S_SCAN,
        S_FIND,
        S_CMD,
        S_DONE
    } t_state;

    t_state r_state;
    t_req   r_req;
    t_rsp   r_out;
    logic   r_out_valid;

    logic [31:0]          r_hold;
    logic [2:0]           r_slot_zone     [SLOT_COUNT];
    logic [31:0]          r_slot_duration [SLOT_COUNT];
    logic [TIME_BITS-1:0] r_slot_start    [SLOT_COUNT];
    logic [TIME_BITS-1:0] r_slot_end      [SLOT_COUNT];
    logic                 r_slot_started  [SLOT_COUNT];
    logic                 r_slot_end_set  [SLOT_COUNT];
    logic [3:0]           r_relay;
    logic                 r_held;
    logic [TIME_BITS-1:0] r_since;

    logic [IDX_W-1:0] r_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_acc;
    logic [3:0]       r_started;
    logic [3:0]       r_stopped;
    logic             r_fired;

    logic                 n_held;
    logic [TIME_BITS-1:0] n_since;
    logic [3:0]           n_occ_mask;

    logic [TIME_BITS-1:0] w_now;
    logic [2:0]           w_cur_zone;
    logic [3:0]           w_cur_bit;
    logic                 w_zone_ok;
    logic [TIME_BITS-1:0] w_a;
    logic [TIME_BITS-1:0] w_b;
    logic [TIME_BITS-1:0] w_sum;
    logic                 w_lt;

    assign w_now      = TIME_BITS'(r_req.current_time);
    assign w_cur_zone = r_slot_zone[r_idx];
    assign w_cur_bit  = zone_bit(w_cur_zone);
    assign w_zone_ok  = (r_req.zone_index != 3'd0) &&
                        (r_req.zone_index <= 3'(ZONE_COUNT));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // override pin tracking for the tick in work
    always_comb begin
        n_held  = r_held;
        n_since = r_since;
        if (!r_req.override_level && !r_held) begin
            n_held  = 1'b1;
            n_since = w_now;
        end else if (r_req.override_level && r_held) begin
            n_held = 1'b0;
        end
    end

    always_comb begin
        n_occ_mask = 4'd0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_slot_zone[i] != 3'd0) begin
                n_occ_mask = n_occ_mask | zone_bit(r_slot_zone[i]);
            end
        end
    end

    // operand select: override deadline, end = start + duration,
    // or timeout test end + 0 < now
    always_comb begin
        w_a = r_slot_end[r_idx];
        w_b = '0;
        if (r_state == S_OVR) begin
            w_a = n_since;
            w_b = TIME_BITS'(r_hold);
        end else if (!r_slot_end_set[r_idx]) begin
            w_a = r_slot_started[r_idx] ? r_slot_start[r_idx] : w_now;
            w_b = TIME_BITS'(r_slot_duration[r_idx]);
        end
    end

    zrt_addcmp #(
        .TIME_BITS(TIME_BITS)
    ) u_addcmp (
        .i_a  (w_a),
        .i_b  (w_b),
        .i_c  (w_now),
        .o_sum(w_sum),
        .o_lt (w_lt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hold      <= HOLD_TIME_RESET;
            r_relay     <= 4'd0;
            r_held      <= 1'b0;
            r_since     <= '0;
            r_idx       <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_zone[i]    <= 3'd0;
                r_slot_started[i] <= 1'b0;
                r_slot_end_set[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            // in S_DONE the load below covers a taken result
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req     <= i_in_data;
                        r_idx     <= '0;
                        r_acc     <= 1'b0;
                        r_started <= 4'd0;
                        r_stopped <= 4'd0;
                        r_fired   <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        unique case (t_opcode'(i_in_data.opcode)) inside
                            OP_TICK:       r_state <= S_OVR;
                            OP_ON, OP_OFF: r_state <= S_FIND;
                            default:       r_state <= S_DONE;
                        endcase
                    end
                end

                S_OVR: begin
                    r_acc   <= 1'b1;
                    r_held  <= n_held && !w_lt;
                    r_since <= n_since;
                    if (n_held && w_lt) begin
                        r_fired   <= 1'b1;
                        r_stopped <= n_occ_mask;
                        r_relay   <= r_relay & ~n_occ_mask;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            r_slot_zone[i]    <= 3'd0;
                            r_slot_started[i] <= 1'b0;
                            r_slot_end_set[i] <= 1'b0;
                        end
                    end
                    r_state <= S_SCAN;
                end

                S_SCAN: begin
                    if (w_cur_zone != 3'd0) begin
                        if (!r_slot_end_set[r_idx]) begin
                            if (!r_slot_started[r_idx]) begin
                                r_slot_started[r_idx] <= 1'b1;
                                r_slot_start[r_idx]   <= w_now;
                                r_relay               <= r_relay | w_cur_bit;
                                r_started             <= r_started | w_cur_bit;
                            end
                            if (r_slot_duration[r_idx] != 32'd0) begin
                                r_slot_end[r_idx]     <= w_sum;
                                r_slot_end_set[r_idx] <= 1'b1;
                            end
                        end else if (w_lt) begin
                            // end time passed: release the slot
                            r_slot_zone[r_idx]    <= 3'd0;
                            r_slot_started[r_idx] <= 1'b0;
                            r_slot_end_set[r_idx] <= 1'b0;
                            r_relay               <= r_relay & ~w_cur_bit;
                            r_stopped             <= r_stopped | w_cur_bit;
                        end
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end
                end

                S_FIND: begin
                    if (w_cur_zone == r_req.zone_index) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (w_cur_zone == 3'd0 && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_CMD;
                    end
                end

                S_CMD: begin
                    if (t_opcode'(r_req.opcode) == OP_ON) begin
                        if (w_zone_ok && !r_hit && r_free) begin
                            r_slot_zone[r_free_idx]     <= r_req.zone_index;
                            r_slot_duration[r_free_idx] <= r_req.run_duration;
                            r_slot_started[r_free_idx]  <= 1'b0;
                            r_slot_end_set[r_free_idx]  <= 1'b0;
                            r_acc                       <= 1'b1;
                        end
                    end else if (w_zone_ok && r_hit) begin
                        r_slot_end[r_hit_idx]     <= w_now;
                        r_slot_end_set[r_hit_idx] <= 1'b1;
                        r_acc                     <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.accepted       <= r_acc;
                        r_out.relay_mask     <= r_relay;
                        r_out.started_mask   <= r_started;
                        r_out.stopped_mask   <= r_stopped;
                        r_out.override_fired <= r_fired;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
